### src/fm_voice_pitch_key_controller_macros.svh
// Assertion macros shared by the pitch/key controller RTL.
`ifndef FM_VOICE_PITCH_KEY_CONTROLLER_MACROS_SVH
`define FM_VOICE_PITCH_KEY_CONTROLLER_MACROS_SVH

// Clocked assertion, ignored while reset is asserted.
`define FVPK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define FVPK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/fvpk_pkg.sv
// Types, constants and lookup functions of the FM voice pitch/key controller.
package fvpk_pkg;

  // Field widths
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned VOICE_W    = 4;
  localparam int unsigned NOTE_W     = 7;
  localparam int unsigned BEND_W     = 14;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned FNUM_W     = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned BHB_W      = 5;
  localparam int unsigned RKEY_W     = 5;

  localparam int unsigned VOICE_COUNT = 11;

  // Event kinds
  typedef enum logic [KIND_W-1:0] {
    K_NOTE_ON  = 2'd0,
    K_NOTE_OFF = 2'd1,
    K_BEND     = 2'd2,
    K_NONE     = 2'd3
  } kind_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERC_MODE   = 2'd0,
    CFG_PITCH_RANGE = 2'd1,
    CFG_AM_DEPTH    = 2'd2,
    CFG_VIB_DEPTH   = 2'd3
  } cfg_idx_e;

  // Voice roles
  localparam logic [VOICE_W-1:0] V_BD      = 4'd6;
  localparam logic [VOICE_W-1:0] V_SD      = 4'd7;
  localparam logic [VOICE_W-1:0] V_TOM     = 4'd8;
  localparam logic [VOICE_W-1:0] V_HH      = 4'd10;
  localparam logic [VOICE_W-1:0] V_MEL_END = 4'd9;

  // Note handling
  localparam logic [NOTE_W-1:0] NOTE_LOW    = 7'd12;
  localparam logic [NOTE_W-1:0] NOTE_HIGH   = 7'd107;
  localparam logic [NOTE_W-1:0] NOTE_CLAMP  = 7'd95;
  localparam logic [NOTE_W-1:0] TOM_NOTE    = 7'd24;
  localparam logic [NOTE_W-1:0] TOM_SD_GAP  = 7'd7;

  // Block/fnum-high bytes of tom and snare at their reset pitch
  localparam logic [BHB_W-1:0] TOM_RST_BHB = 5'd9;
  localparam logic [BHB_W-1:0] SD_RST_BHB  = 5'd10;

  localparam logic [BEND_W-1:0] MID_BEND = 14'h2000;
  localparam int unsigned BEND_SHIFT = 13;

  localparam logic [FNUM_W:0] FNUM_MAX = 11'h3ff;
  localparam logic [FNUM_W:0] FNUM_MIN = 11'd343;

  localparam logic [3:0] RANGE_MAX = 4'd12;
  localparam logic [4:0] SEMIS     = 5'd12;

  // Chip register addresses
  localparam logic [BYTE_W-1:0] ADDR_FLO = 8'hA0;
  localparam logic [BYTE_W-1:0] ADDR_FHI = 8'hB0;
  localparam logic [BYTE_W-1:0] ADDR_RHY = 8'hBD;

  // Half-tone frequency numbers
  function automatic logic [FNUM_W-1:0] fnum_lut(input logic [3:0] idx);
    logic [FNUM_W-1:0] f;
    case (idx)
      4'd0:    f = 10'd343;
      4'd1:    f = 10'd363;
      4'd2:    f = 10'd385;
      4'd3:    f = 10'd408;
      4'd4:    f = 10'd432;
      4'd5:    f = 10'd458;
      4'd6:    f = 10'd485;
      4'd7:    f = 10'd514;
      4'd8:    f = 10'd544;
      4'd9:    f = 10'd577;
      4'd10:   f = 10'd611;
      4'd11:   f = 10'd647;
      default: f = '0;
    endcase
    return f;
  endfunction

  // Rhythm key bit of a percussion voice, bass drum first
  function automatic logic [RKEY_W-1:0] perc_mask(input logic [2:0] idx);
    logic [RKEY_W-1:0] m;
    case (idx)
      3'd0:    m = 5'h10;
      3'd1:    m = 5'h08;
      3'd2:    m = 5'h04;
      3'd3:    m = 5'h02;
      3'd4:    m = 5'h01;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

### src/fvpk_if.sv
// Valid/ready channel interfaces: event words in, register write words out.
interface fvpk_in_if import fvpk_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [VOICE_W-1:0]   voice;
  logic [NOTE_W-1:0]    note;
  logic [BEND_W-1:0]    bend;

  modport source (output valid, kind, voice, note, bend, input ready);
  modport sink   (input valid, kind, voice, note, bend, output ready);
endinterface

interface fvpk_out_if import fvpk_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [BYTE_W-1:0]    reg_addr;
  logic [BYTE_W-1:0]    reg_data;
  logic                 last;

  modport source (output valid, reg_addr, reg_data, last, input ready);
  modport sink   (input valid, reg_addr, reg_data, last, output ready);
endinterface

### src/fm_voice_pitch_key_controller.sv
// Sequence: S_IDLE takes the event word, S_EXEC plans it; a frequency job runs S_F_DIV,
// S_F_TGT (S_F_MUL, S_F_ADD, S_F_NORM only when bent), S_F_LO, S_F_HI; a note-off or
// rhythm-only event goes to S_KOFF or S_RHY. One event at a time: a new event word is taken
// only in S_IDLE. One shared multiply/add/shift step a cycle, at most one normalize shift.
// Output stalls hold the write states. Reset: asynchronous, active low; tom note 24, snare
// 31, bends centered, keys and block bytes cleared, perc_mode 0, pitch_range 1, depths 0.
`include "fm_voice_pitch_key_controller_macros.svh"

module fm_voice_pitch_key_controller import fvpk_pkg::*; #(
  parameter int unsigned VoiceCount = VOICE_COUNT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  fvpk_in_if.sink               in_i,
  fvpk_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned VIdxW = $clog2(VoiceCount);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_F_DIV, S_F_TGT, S_F_MUL, S_F_ADD, S_F_NORM,
    S_F_LO, S_F_HI, S_RHY, S_KOFF
  } state_e;

  state_e state_q;

  // Configuration registers
  logic       perc_q, am_q, vib_q;
  logic [3:0] range_q;

  // Per-voice state
  logic [NOTE_W-1:0] note_q [VoiceCount];
  logic [BEND_W-1:0] bend_q [VoiceCount];
  logic              key_q  [VoiceCount];
  logic [BHB_W-1:0]  bhb_q  [VoiceCount];
  logic [RKEY_W-1:0] rkeys_q;

  // Captured event word
  kind_e             ev_kind_q;
  logic [VOICE_W-1:0] ev_voice_q;
  logic [NOTE_W-1:0] ev_note_q;
  logic [BEND_W-1:0] ev_bend_q;

  // Job flags and current voice
  logic              second_q, rhy_q;
  logic [VIdxW-1:0]  cv_q;

  // Shared arithmetic unit registers
  logic [2:0]        oct_q;
  logic [3:0]        rem_q;
  logic              up_q, dn_q;
  logic [BEND_W-1:0] d_q;
  logic [FNUM_W:0]   fnum_q;
  logic [FNUM_W-1:0] t_q;
  logic [FNUM_W+BEND_W-1:0] prod_q;

  // Output register
  logic              out_vld_q;
  logic [BYTE_W-1:0] out_addr_q, out_data_q;
  logic              out_last_q;

  // Comb signals
  logic [NOTE_W-1:0] clamp_note;
  logic              melodic, percv, bend_ok, out_free;
  logic [3:0]        r_eff;
  logic [NOTE_W-1:0] cur_note;
  logic [BEND_W-1:0] cur_bend;
  logic [12:0]       div_prod;
  logic [3:0]        oct_full, rem;
  logic [4:0]        up_sum, dn_sum;
  logic [3:0]        up_idx, dn_idx;
  logic [FNUM_W-1:0] fnum0, tt;
  logic [FNUM_W:0]   tadj;
  logic [FNUM_W:0]   delta;
  logic [VIdxW-1:0]  ev_idx;
  logic [2:0]        pidx;

  assign in_i.ready     = (state_q == S_IDLE);
  assign out_o.valid    = out_vld_q;
  assign out_o.reg_addr = out_addr_q;
  assign out_o.reg_data = out_data_q;
  assign out_o.last     = out_last_q;
  assign out_free       = !out_vld_q || out_o.ready;

  // Note clamp into the table's octave range
  always_comb begin
    if (in_i.note <= NOTE_LOW) begin
      clamp_note = '0;
    end else if (in_i.note > NOTE_HIGH) begin
      clamp_note = NOTE_CLAMP;
    end else begin
      clamp_note = in_i.note - NOTE_LOW;
    end
  end

  // Voice class of the captured event
  assign ev_idx  = VIdxW'(ev_voice_q);
  assign pidx    = 3'(ev_voice_q - V_BD);
  assign melodic = perc_q ? (ev_voice_q < V_BD) : (ev_voice_q < V_MEL_END);
  assign percv   = perc_q && (ev_voice_q >= V_BD) && (ev_voice_q <= V_HH);
  assign bend_ok = perc_q ? (ev_voice_q <= V_BD) : (ev_voice_q < V_MEL_END);

  // Effective bend range
  always_comb begin
    if (range_q == 4'd0) begin
      r_eff = 4'd1;
    end else if (range_q > RANGE_MAX) begin
      r_eff = RANGE_MAX;
    end else begin
      r_eff = range_q;
    end
  end

  // Octave and half-tone of the current voice: note * 43 >> 9 is note / 12 here
  assign cur_note = note_q[cv_q];
  assign cur_bend = bend_q[cv_q];
  assign div_prod = 13'(cur_note) * 13'd43;
  assign oct_full = div_prod[12:9];
  assign rem      = 4'(cur_note - 7'(oct_full) * 7'd12);

  // Bend target half-tones, wrapped into one octave
  assign up_sum = 5'(rem_q) + 5'(r_eff);
  assign dn_sum = 5'(rem_q) + SEMIS - 5'(r_eff);
  assign up_idx = (up_sum >= SEMIS) ? 4'(up_sum - SEMIS) : up_sum[3:0];
  assign dn_idx = (dn_sum >= SEMIS) ? 4'(dn_sum - SEMIS) : dn_sum[3:0];
  assign fnum0  = fnum_lut(rem_q);
  assign tt     = fnum_lut(up_q ? up_idx : dn_idx);

  // Distance to the target, folded by an octave when it lies on the wrong side
  always_comb begin
    if (up_q) begin
      if (tt < fnum0) begin
        tadj = {tt, 1'b0} - {1'b0, fnum0};
      end else begin
        tadj = {1'b0, tt} - {1'b0, fnum0};
      end
    end else begin
      if (tt > fnum0) begin
        tadj = {1'b0, fnum0} - {2'b0, tt[FNUM_W-1:1]};
      end else begin
        tadj = {1'b0, fnum0} - {1'b0, tt};
      end
    end
  end

  assign delta = (FNUM_W+1)'(prod_q >> BEND_SHIFT);

  // Sequencer, datapath, state and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      perc_q    <= 1'b0;
      am_q      <= 1'b0;
      vib_q     <= 1'b0;
      range_q   <= 4'd1;
      rkeys_q   <= '0;
      second_q  <= 1'b0;
      rhy_q     <= 1'b0;
      cv_q      <= '0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < VoiceCount; i++) begin
        note_q[i] <= '0;
        bend_q[i] <= MID_BEND;
        key_q[i]  <= 1'b0;
        bhb_q[i]  <= '0;
      end
      note_q[VIdxW'(V_TOM)] <= TOM_NOTE;
      note_q[VIdxW'(V_SD)]  <= TOM_NOTE + TOM_SD_GAP;
    end else begin
      if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            ev_kind_q  <= kind_e'(in_i.kind);
            ev_voice_q <= in_i.voice;
            ev_note_q  <= clamp_note;
            ev_bend_q  <= in_i.bend;
            state_q    <= S_EXEC;
          end
        end

        // Update voice state and plan the writes of this event
        S_EXEC: begin
          second_q <= 1'b0;
          rhy_q    <= 1'b0;
          state_q  <= S_IDLE;
          case (ev_kind_q)
            K_NOTE_ON: begin
              if (melodic) begin
                note_q[ev_idx] <= ev_note_q;
                key_q[ev_idx]  <= 1'b1;
                cv_q           <= ev_idx;
                state_q        <= S_F_DIV;
              end else if (percv) begin
                rkeys_q <= rkeys_q | perc_mask(pidx);
                rhy_q   <= 1'b1;
                state_q <= S_RHY;
                if (ev_voice_q == V_BD) begin
                  note_q[VIdxW'(V_BD)] <= ev_note_q;
                  cv_q                 <= VIdxW'(V_BD);
                  state_q              <= S_F_DIV;
                end else if (ev_voice_q == V_TOM &&
                             note_q[VIdxW'(V_TOM)] != ev_note_q) begin
                  note_q[VIdxW'(V_TOM)] <= ev_note_q;
                  note_q[VIdxW'(V_SD)]  <= ev_note_q + TOM_SD_GAP;
                  cv_q                  <= VIdxW'(V_TOM);
                  second_q              <= 1'b1;
                  state_q               <= S_F_DIV;
                end
              end
            end
            K_NOTE_OFF: begin
              if (melodic) begin
                key_q[ev_idx] <= 1'b0;
                cv_q          <= ev_idx;
                state_q       <= S_KOFF;
              end else if (percv) begin
                rkeys_q <= rkeys_q & ~perc_mask(pidx);
                rhy_q   <= 1'b1;
                state_q <= S_RHY;
              end
            end
            K_BEND: begin
              if (bend_ok) begin
                bend_q[ev_idx] <= ev_bend_q;
                cv_q           <= ev_idx;
                state_q        <= S_F_DIV;
              end
            end
            default: state_q <= S_IDLE;
          endcase
        end

        // Split the note and the bend deflection
        S_F_DIV: begin
          oct_q   <= oct_full[2:0];
          rem_q   <= rem;
          up_q    <= cur_bend > MID_BEND;
          dn_q    <= cur_bend < MID_BEND;
          d_q     <= (cur_bend > MID_BEND) ? cur_bend - MID_BEND : MID_BEND - cur_bend;
          state_q <= S_F_TGT;
        end

        S_F_TGT: begin
          fnum_q  <= {1'b0, fnum0};
          t_q     <= tadj[FNUM_W-1:0];
          state_q <= (up_q || dn_q) ? S_F_MUL : S_F_LO;
        end

        S_F_MUL: begin
          prod_q  <= t_q * d_q;
          state_q <= S_F_ADD;
        end

        S_F_ADD: begin
          fnum_q  <= up_q ? fnum_q + delta : fnum_q - delta;
          state_q <= S_F_NORM;
        end

        // Renormalize by octave, one shift a cycle
        S_F_NORM: begin
          if (up_q && fnum_q > FNUM_MAX) begin
            fnum_q <= fnum_q >> 1;
            oct_q  <= oct_q + 3'd1;
          end else if (dn_q && fnum_q < FNUM_MIN) begin
            fnum_q <= fnum_q << 1;
            oct_q  <= oct_q - 3'd1;
          end else begin
            state_q <= S_F_LO;
          end
        end

        S_F_LO: begin
          if (out_free) begin
            out_vld_q   <= 1'b1;
            out_addr_q  <= ADDR_FLO + BYTE_W'(cv_q);
            out_data_q  <= fnum_q[7:0];
            out_last_q  <= 1'b0;
            bhb_q[cv_q] <= {oct_q, fnum_q[9:8]};
            state_q     <= S_F_HI;
          end
        end

        S_F_HI: begin
          if (out_free) begin
            out_vld_q  <= 1'b1;
            out_addr_q <= ADDR_FHI + BYTE_W'(cv_q);
            out_data_q <= {2'b0, key_q[cv_q], bhb_q[cv_q]};
            out_last_q <= !second_q && !rhy_q;
            if (second_q) begin
              second_q <= 1'b0;
              cv_q     <= VIdxW'(V_SD);
              state_q  <= S_F_DIV;
            end else if (rhy_q) begin
              state_q <= S_RHY;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end

        S_RHY: begin
          if (out_free) begin
            out_vld_q  <= 1'b1;
            out_addr_q <= ADDR_RHY;
            out_data_q <= {am_q, vib_q, perc_q, rkeys_q};
            out_last_q <= 1'b1;
            rhy_q      <= 1'b0;
            state_q    <= S_IDLE;
          end
        end

        S_KOFF: begin
          if (out_free) begin
            out_vld_q  <= 1'b1;
            out_addr_q <= ADDR_FHI + BYTE_W'(cv_q);
            out_data_q <= {3'b0, bhb_q[cv_q]};
            out_last_q <= 1'b1;
            state_q    <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase

      // Register writes; the sender must issue them only while no event is in flight (not enforced here)
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_PERC_MODE: begin
            perc_q  <= cfg_data_i[0];
            rkeys_q <= '0;
            if (cfg_data_i[0]) begin
              note_q[VIdxW'(V_TOM)] <= TOM_NOTE;
              bend_q[VIdxW'(V_TOM)] <= MID_BEND;
              bhb_q[VIdxW'(V_TOM)]  <= TOM_RST_BHB;
              note_q[VIdxW'(V_SD)]  <= TOM_NOTE + TOM_SD_GAP;
              bend_q[VIdxW'(V_SD)]  <= MID_BEND;
              bhb_q[VIdxW'(V_SD)]   <= SD_RST_BHB;
            end
          end
          CFG_PITCH_RANGE: range_q <= cfg_data_i;
          CFG_AM_DEPTH:    am_q    <= cfg_data_i[0];
          CFG_VIB_DEPTH:   vib_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // Normalized frequency number lies between FNUM_MIN and FNUM_MAX in S_F_LO
  `FVPK_ASSERT(a_fnum_norm, (state_q == S_F_LO) |-> (fnum_q >= FNUM_MIN && fnum_q <= FNUM_MAX), "fnum not normalized")
  // Only a tom note change chains a second frequency pair, for the snare
  `FVPK_ASSERT(a_second_tom, second_q |-> (cv_q == VIdxW'(V_TOM)), "second pair without tom")
  // No pending job survives into idle
  `FVPK_ASSERT_ALWAYS(a_idle_clean, (state_q == S_IDLE) |-> (!second_q && !rhy_q), "job left pending")
  // A rhythm byte always closes its event
  `FVPK_ASSERT(a_rhy_last, (out_vld_q && out_addr_q == ADDR_RHY) |-> out_last_q, "rhythm word not last")

endmodule

### test/fm_voice_pitch_key_controller_test.sv
// Self-checking testbench of the FM voice pitch/key controller: events in, register writes checked.
module fm_voice_pitch_key_controller_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fvpk_pkg::*;

  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SEGMENTS      = 9;
  localparam int unsigned SEG_EVENTS    = 45;
  localparam int unsigned MAX_REPORTS   = 100;

  localparam int unsigned HALF_TONE_FNUM [12] = '{343, 363, 385, 408, 432, 458,
                                                  485, 514, 544, 577, 611, 647};

  typedef struct packed {
    logic [BYTE_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic              last;
  } reg_write_t;

  typedef enum logic {ROW_EVENT, ROW_REG} row_e;

  // One row of the directed table: an event word or a register write
  typedef struct packed {
    row_e                  what;
    kind_e                 kind;
    logic [VOICE_W-1:0]    voice;
    logic [NOTE_W-1:0]     note;
    logic [BEND_W-1:0]     bend;
    cfg_idx_e              reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  typed;
    logic [1:0]            n_typed;
    logic [BYTE_W-1:0]     a0;
    logic [BYTE_W-1:0]     d0;
    logic [BYTE_W-1:0]     a1;
    logic [BYTE_W-1:0]     d1;
  } step_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  fvpk_in_if  ev_ch ();
  fvpk_out_if wr_ch ();

  fm_voice_pitch_key_controller i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (ev_ch),
    .out_o      (wr_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predicted voice state and registers
  logic [NOTE_W-1:0] note_of    [VOICE_COUNT];
  logic [BEND_W-1:0] bend_of    [VOICE_COUNT];
  logic              key_on     [VOICE_COUNT];
  logic [BHB_W-1:0]  block_byte [VOICE_COUNT];
  logic [RKEY_W-1:0] drum_keys;
  logic              perc_on;
  logic [3:0]        range_reg;
  logic              am_on;
  logic              vib_on;

  reg_write_t  event_writes[$];    // writes of the latest accepted event
  reg_write_t  pending_writes[$];  // writes still owed by the block
  step_t       directed[$];
  int unsigned mismatches;
  int unsigned send_gap_pct;
  int unsigned take_stall_pct;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  // Low fnum byte of a voice after bend and octave renormalization; updates its block byte
  function automatic logic [7:0] refresh_freq(int unsigned v);
    int unsigned nt, bd, r, oct, fnum, t, d;
    nt = note_of[v];
    bd = bend_of[v];
    r = range_reg;
    if (r < 1) r = 1;
    if (r > 12) r = 12;
    oct = nt / 12;
    fnum = HALF_TONE_FNUM[nt % 12];
    if (bd > MID_BEND) begin
      d = bd - MID_BEND;
      t = HALF_TONE_FNUM[(nt + r) % 12];
      if (t < fnum) t = t << 1;
      t = t - fnum;
      fnum = fnum + ((t * d) >> BEND_SHIFT);
      while (fnum > 'h3ff) begin
        fnum = fnum >> 1;
        oct = (oct + 1) % 8;
      end
    end else if (bd < MID_BEND) begin
      d = MID_BEND - bd;
      t = HALF_TONE_FNUM[(nt % 12 + 12 - r) % 12];
      if (t > fnum) t = t >> 1;
      t = fnum - t;
      fnum = fnum - ((t * d) >> BEND_SHIFT);
      while (fnum < HALF_TONE_FNUM[0]) begin
        fnum = fnum << 1;
        oct = (oct + 7) % 8;
      end
    end
    block_byte[v] = 5'((oct << 2) | ((fnum >> 8) & 3));
    return 8'(fnum);
  endfunction

  function automatic void put_write(logic [7:0] addr, logic [7:0] data);
    reg_write_t w;
    w.addr = addr;
    w.data = data;
    w.last = 1'b0;
    event_writes.push_back(w);
  endfunction

  function automatic void put_freq(int unsigned v);
    logic [7:0] lo;
    lo = refresh_freq(v);
    put_write(ADDR_FLO + 8'(v), lo);
    put_write(ADDR_FHI + 8'(v), {2'b00, key_on[v], block_byte[v]});
  endfunction

  function automatic void put_rhythm();
    put_write(ADDR_RHY, {am_on, vib_on, perc_on, drum_keys});
  endfunction

  // Register writes caused by one event word
  function automatic void predict_event(kind_e kind, int unsigned v, int unsigned note,
                                        logic [BEND_W-1:0] bend);
    logic              melodic;
    logic              drum;
    logic [RKEY_W-1:0] mask;
    int unsigned       p;
    reg_write_t        w;
    event_writes.delete();
    melodic = perc_on ? (v < V_BD) : (v < V_MEL_END);
    drum = perc_on && v >= V_BD && v <= V_HH;
    mask = drum ? (5'h10 >> (v - V_BD)) : '0;
    case (kind)
      K_NOTE_ON: begin
        if (note <= NOTE_LOW) p = 0;
        else if (note > NOTE_HIGH) p = NOTE_CLAMP;
        else p = note - NOTE_LOW;
        if (melodic) begin
          note_of[v] = 7'(p);
          key_on[v] = 1'b1;
          put_freq(v);
        end else if (drum) begin
          if (v == V_BD) begin
            note_of[v] = 7'(p);
            put_freq(v);
          end else if (v == V_TOM && note_of[V_TOM] != p) begin
            // tom retune drags the snare along
            note_of[V_TOM] = 7'(p);
            note_of[V_SD] = 7'(p + TOM_SD_GAP);
            put_freq(V_TOM);
            put_freq(V_SD);
          end
          drum_keys = drum_keys | mask;
          put_rhythm();
        end
      end
      K_NOTE_OFF: begin
        if (melodic) begin
          key_on[v] = 1'b0;
          put_write(ADDR_FHI + 8'(v), {3'b000, block_byte[v]});
        end else if (drum) begin
          drum_keys = drum_keys & ~mask;
          put_rhythm();
        end
      end
      K_BEND: begin
        if (perc_on ? (v <= V_BD) : (v < V_MEL_END)) begin
          bend_of[v] = bend;
          put_freq(v);
        end
      end
      default: ;
    endcase
    if (event_writes.size() != 0) begin
      w = event_writes.pop_back();
      w.last = 1'b1;
      event_writes.push_back(w);
    end
  endfunction

  function automatic void apply_reg_write(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_PERC_MODE: begin
        perc_on = val[0];
        drum_keys = '0;
        if (perc_on) begin
          note_of[V_TOM] = TOM_NOTE;
          bend_of[V_TOM] = MID_BEND;
          void'(refresh_freq(V_TOM));
          note_of[V_SD] = TOM_NOTE + TOM_SD_GAP;
          bend_of[V_SD] = MID_BEND;
          void'(refresh_freq(V_SD));
        end
      end
      CFG_PITCH_RANGE: range_reg = val;
      CFG_AM_DEPTH:    am_on = val[0];
      CFG_VIB_DEPTH:   vib_on = val[0];
      default: ;
    endcase
  endfunction

  // Table row builders
  function automatic step_t ev(kind_e k, logic [3:0] v, logic [6:0] n, logic [13:0] b);
    step_t s;
    s = '0;
    s.what = ROW_EVENT;
    s.kind = k;
    s.voice = v;
    s.note = n;
    s.bend = b;
    return s;
  endfunction

  function automatic step_t evk(kind_e k, logic [3:0] v, logic [6:0] n, logic [13:0] b,
                                logic [1:0] cnt, logic [7:0] a0, logic [7:0] d0,
                                logic [7:0] a1, logic [7:0] d1);
    step_t s;
    s = ev(k, v, n, b);
    s.typed = 1'b1;
    s.n_typed = cnt;
    s.a0 = a0;
    s.d0 = d0;
    s.a1 = a1;
    s.d1 = d1;
    return s;
  endfunction

  function automatic step_t rw(cfg_idx_e idx, logic [3:0] val);
    step_t s;
    s = '0;
    s.what = ROW_REG;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  // Random event word, weighted toward extremes and active voices
  function automatic step_t random_step();
    step_t       s;
    int unsigned r;
    s = '0;
    s.what = ROW_EVENT;
    r = $urandom_range(99);
    if (r < 40) s.kind = K_NOTE_ON;
    else if (r < 65) s.kind = K_NOTE_OFF;
    else if (r < 95) s.kind = K_BEND;
    else s.kind = K_NONE;
    if ($urandom_range(9) != 0) s.voice = 4'($urandom_range(10));
    else s.voice = 4'($urandom_range(15, 11));
    r = $urandom_range(99);
    if (r < 10) s.note = 7'($urandom_range(12));
    else if (r < 20) s.note = 7'($urandom_range(127, 108));
    else s.note = 7'($urandom_range(107, 13));
    // replay the current tom pitch now and then: no retune expected
    if (s.kind == K_NOTE_ON && s.voice == V_TOM && $urandom_range(2) == 0)
      s.note = note_of[V_TOM] + NOTE_LOW;
    r = $urandom_range(99);
    if (r < 15) s.bend = '0;
    else if (r < 30) s.bend = '1;
    else if (r < 40) s.bend = MID_BEND;
    else if (r < 50) s.bend = MID_BEND + 14'($urandom_range(32)) - 14'd16;
    else s.bend = 14'($urandom_range(16383));
    return s;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_REPORTS) $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    apply_reg_write(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop offering, wait for every owed write, then let the block go quiet
  task automatic settle();
    ev_ch.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_step(step_t s);
    reg_write_t w;
    while ($urandom_range(99) < send_gap_pct) begin
      ev_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    ev_ch.valid <= 1'b1;
    ev_ch.kind <= s.kind;
    ev_ch.voice <= s.voice;
    ev_ch.note <= s.note;
    ev_ch.bend <= s.bend;
    do @(posedge clk_i); while (!ev_ch.ready);
    predict_event(s.kind, s.voice, s.note, s.bend);
    if (s.typed) begin
      // writes typed into the table replace the predicted ones
      for (int unsigned i = 0; i < s.n_typed; i++) begin
        w.addr = (i == 0) ? s.a0 : s.a1;
        w.data = (i == 0) ? s.d0 : s.d1;
        w.last = (i + 1 == s.n_typed);
        pending_writes.push_back(w);
      end
    end else begin
      foreach (event_writes[i]) pending_writes.push_back(event_writes[i]);
    end
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus long hold-offs on request
  initial begin
    wr_ch.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        wr_ch.ready <= 1'b0;
      end else begin
        wr_ch.ready <= ($urandom_range(99) >= take_stall_pct);
      end
    end
  end

  // Compare each accepted write word with the oldest one owed
  always @(posedge clk_i) begin : check_writes
    reg_write_t want;
    if (rst_ni && wr_ch.valid && wr_ch.ready) begin
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected write 0x%02h <= 0x%02h",
                                  wr_ch.reg_addr, wr_ch.reg_data));
      end else begin
        want = pending_writes.pop_front();
        if (wr_ch.reg_addr !== want.addr)
          report_mismatch($sformatf("reg_addr 0x%02h, expected 0x%02h",
                                    wr_ch.reg_addr, want.addr));
        if (wr_ch.reg_data !== want.data)
          report_mismatch($sformatf("reg_data 0x%02h at 0x%02h, expected 0x%02h",
                                    wr_ch.reg_data, want.addr, want.data));
        if (wr_ch.last !== want.last)
          report_mismatch($sformatf("last %b at 0x%02h, expected %b",
                                    wr_ch.last, want.addr, want.last));
      end
    end
  end

  // Watchdog on cycles with no word moving on any port
  always @(posedge clk_i) begin
    if (!rst_ni || (ev_ch.valid && ev_ch.ready) || (wr_ch.valid && wr_ch.ready) || cfg_we_i)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL fm_voice_pitch_key_controller");
      $finish;
    end
  end

  // Stimulus
  initial begin
    step_t       s;
    int unsigned produced;
    bit          held;
    logic        perc_sel;
    logic [3:0]  range_sel;
    logic        am_sel;
    logic        vib_sel;

    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_PERC_MODE;
    cfg_data_i <= '0;
    ev_ch.valid <= 1'b0;
    ev_ch.kind <= K_NONE;
    ev_ch.voice <= '0;
    ev_ch.note <= '0;
    ev_ch.bend <= '0;
    hold_req = 1'b0;
    mismatches = 0;
    quiet_cycles = 0;
    send_gap_pct = 14;
    take_stall_pct = 47;

    // state after reset
    for (int i = 0; i < VOICE_COUNT; i++) begin
      note_of[i] = '0;
      bend_of[i] = MID_BEND;
      key_on[i] = 1'b0;
      block_byte[i] = '0;
    end
    note_of[V_TOM] = TOM_NOTE;
    note_of[V_SD] = TOM_NOTE + TOM_SD_GAP;
    drum_keys = '0;
    perc_on = 1'b0;
    range_reg = 4'd1;
    am_on = 1'b0;
    vib_on = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: melodic mode first, then rhythm mode, back to melodic mode at the end
    directed.push_back(evk(K_NOTE_OFF, 4'd0, 7'd0, MID_BEND, 2'd1, ADDR_FHI, 8'h00, 8'h00, 8'h00));
    directed.push_back(evk(K_NOTE_ON, 4'd0, 7'd0, MID_BEND, 2'd2, ADDR_FLO, 8'h57, ADDR_FHI, 8'h21));
    directed.push_back(evk(K_NONE, 4'd0, 7'd60, MID_BEND, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    directed.push_back(evk(K_NOTE_ON, 4'd15, 7'd60, MID_BEND, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    directed.push_back(evk(K_NOTE_ON, 4'd9, 7'd60, MID_BEND, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    directed.push_back(evk(K_NOTE_ON, 4'd8, 7'd127, MID_BEND, 2'd2,
                           ADDR_FLO + 8'd8, 8'h87, ADDR_FHI + 8'd8, 8'h3E));
    directed.push_back(ev(K_BEND, 4'd0, 7'd0, 14'd0));          // octave wraps below zero
    directed.push_back(ev(K_BEND, 4'd0, 7'd0, 14'h3fff));
    directed.push_back(evk(K_NOTE_ON, 4'd1, 7'd12, MID_BEND, 2'd2,
                           ADDR_FLO + 8'd1, 8'h57, ADDR_FHI + 8'd1, 8'h21));
    directed.push_back(evk(K_NOTE_ON, 4'd2, 7'd13, MID_BEND, 2'd2,
                           ADDR_FLO + 8'd2, 8'h6B, ADDR_FHI + 8'd2, 8'h21));
    directed.push_back(evk(K_NOTE_ON, 4'd3, 7'd107, MID_BEND, 2'd2,
                           ADDR_FLO + 8'd3, 8'h87, ADDR_FHI + 8'd3, 8'h3E));
    directed.push_back(evk(K_NOTE_ON, 4'd4, 7'd108, MID_BEND, 2'd2,
                           ADDR_FLO + 8'd4, 8'h87, ADDR_FHI + 8'd4, 8'h3E));
    directed.push_back(rw(CFG_PITCH_RANGE, 4'd11));
    directed.push_back(ev(K_BEND, 4'd8, 7'd0, 14'h3fff));       // octave wraps past seven
    directed.push_back(rw(CFG_PITCH_RANGE, 4'd0));              // plays as one
    directed.push_back(ev(K_BEND, 4'd3, 7'd0, 14'd100));
    directed.push_back(rw(CFG_PITCH_RANGE, 4'd15));             // plays as twelve
    directed.push_back(ev(K_BEND, 4'd4, 7'd0, 14'd0));
    directed.push_back(ev(K_NOTE_OFF, 4'd8, 7'd0, MID_BEND));
    directed.push_back(rw(CFG_PERC_MODE, 4'd1));
    directed.push_back(rw(CFG_AM_DEPTH, 4'd1));
    directed.push_back(rw(CFG_VIB_DEPTH, 4'd1));
    directed.push_back(evk(K_NOTE_ON, 4'd7, 7'd60, MID_BEND, 2'd1, ADDR_RHY, 8'hE8, 8'h00, 8'h00));
    directed.push_back(ev(K_NOTE_ON, 4'd6, 7'd60, MID_BEND));
    // tom already at this pitch: rhythm byte only
    directed.push_back(evk(K_NOTE_ON, 4'd8, 7'd36, MID_BEND, 2'd1, ADDR_RHY, 8'hFC, 8'h00, 8'h00));
    directed.push_back(ev(K_NOTE_ON, 4'd8, 7'd50, MID_BEND));
    directed.push_back(ev(K_NOTE_ON, 4'd9, 7'd70, MID_BEND));
    directed.push_back(ev(K_NOTE_ON, 4'd10, 7'd70, MID_BEND));
    directed.push_back(ev(K_NOTE_OFF, 4'd6, 7'd0, MID_BEND));
    directed.push_back(ev(K_BEND, 4'd6, 7'd0, 14'd5000));
    directed.push_back(evk(K_BEND, 4'd7, 7'd0, 14'd5000, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    directed.push_back(evk(K_NOTE_ON, 4'd11, 7'd60, MID_BEND, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    directed.push_back(ev(K_NOTE_OFF, 4'd2, 7'd0, MID_BEND));
    directed.push_back(rw(CFG_PERC_MODE, 4'd0));

    foreach (directed[i]) begin
      if (directed[i].what == ROW_REG) begin
        settle();
        write_reg(directed[i].reg_idx, directed[i].reg_val);
      end else begin
        send_step(directed[i]);
      end
    end

    // Random segments, each under its own register setting
    for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 3) begin
        send_gap_pct = 14;
        take_stall_pct = 47;
      end else if (seg < 6) begin
        send_gap_pct = 47;
        take_stall_pct = 14;
      end else begin
        send_gap_pct = 0;
        take_stall_pct = 0;
      end
      case (seg)
        0: {perc_sel, range_sel, am_sel, vib_sel} = {1'b0, 4'd1, 1'b0, 1'b0};
        1: {perc_sel, range_sel, am_sel, vib_sel} = {1'b1, 4'd12, 1'b1, 1'b1};
        2: {perc_sel, range_sel, am_sel, vib_sel} = {1'b1, 4'd0, 1'b0, 1'b1};
        3: {perc_sel, range_sel, am_sel, vib_sel} = {1'b0, 4'd15, 1'b1, 1'b0};
        default: begin
          perc_sel = 1'($urandom_range(1));
          range_sel = 4'($urandom_range(15));
          am_sel = 1'($urandom_range(1));
          vib_sel = 1'($urandom_range(1));
        end
      endcase
      settle();
      // upper data bits are don't-care for the one-bit registers
      write_reg(CFG_PERC_MODE, {3'($urandom_range(7)), perc_sel});
      write_reg(CFG_PITCH_RANGE, range_sel);
      write_reg(CFG_AM_DEPTH, {3'($urandom_range(7)), am_sel});
      write_reg(CFG_VIB_DEPTH, {3'($urandom_range(7)), vib_sel});

      produced = 0;
      held = 1'b0;
      while (produced < SEG_EVENTS) begin
        if ((seg == 2 || seg == 7) && produced == 10 && !held) begin
          hold_req = 1'b1;
          held = 1'b1;
        end
        s = random_step();
        send_step(s);
        produced++;
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("PASS fm_voice_pitch_key_controller");
    end else begin
      $display("FAIL fm_voice_pitch_key_controller");
    end
    $finish;
  end

endmodule
